// ----- sv/pls_pkg.sv -----
// Package for the positional sequential list: command and status codes,
// controller state type, control struct, default capacity and word widths. No dependencies.
`timescale 1ns / 1ps

package pls_pkg;

   localparam int PLS_CAPACITY = 16;

   // Word widths on the stream ports, padded to whole bytes.
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_SEARCH = 2'd2;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_FULL   = 2'd1;
   localparam logic [1:0] STAT_EMPTY  = 2'd2;
   localparam logic [1:0] STAT_BADPOS = 2'd3;

   typedef enum logic {
      S_IDLE,
      S_HOLD
   } pls_state_type;

   typedef struct packed {
      logic exec;
   } pls_cmd_type;

endpackage

// ----- sv/pls_ctrl.sv -----
// Controller for the positional sequential list: tracks whether the result
// register holds a word and issues the execute command. Uses pls_pkg.
`timescale 1ns / 1ps

module pls_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output pls_pkg::pls_cmd_type cmd
);

   pls_pkg::pls_state_type state_ff;
   pls_pkg::pls_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pls_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pls_pkg::S_IDLE: begin
            if (cmd.exec) begin
               state_in = pls_pkg::S_HOLD;
            end
         end
         pls_pkg::S_HOLD: begin
            if (cmd.exec) begin
               state_in = pls_pkg::S_HOLD;
            end else if (rsp_tready) begin
               state_in = pls_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pls_pkg::S_IDLE;
         end
      endcase
   end

   // A new word is taken whenever the result register is empty or is being
   // drained in the same cycle.
   always_comb begin
      rsp_tvalid = 1'b0;
      req_tready = 1'b0;
      case (state_ff)
         pls_pkg::S_IDLE: begin
            req_tready = 1'b1;
         end
         pls_pkg::S_HOLD: begin
            rsp_tvalid = 1'b1;
            req_tready = rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      cmd.exec = req_tvalid && req_tready;
   end

endmodule

// ----- sv/pls_dp.sv -----
// Datapath for the positional sequential list: the entry register chain,
// the held count and the result register. Uses pls_pkg.
`timescale 1ns / 1ps

module pls_dp #(
   parameter int CAPACITY = pls_pkg::PLS_CAPACITY
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pls_pkg::pls_cmd_type             cmd,
   input  logic [1:0]                       command,
   input  logic [4:0]                       position,
   input  logic signed [31:0]               value,
   output logic [pls_pkg::RSP_DATA_W-1:0]   rsp_word
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int IXW  = $clog2(CAPACITY);
   localparam int CMPW = (CW > 5) ? CW : 5;

   logic [31:0]         entries_ff [CAPACITY];
   logic [31:0]         entries_in [CAPACITY];
   logic [31:0]         shift_up   [CAPACITY];
   logic [31:0]         shift_down [CAPACITY];
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic [CAPACITY-1:0] hit;
   logic [CMPW-1:0]     pos_x;
   logic [CMPW-1:0]     cnt_x;
   logic [IXW-1:0]      rm_idx;
   logic                do_ins;
   logic                do_rem;
   logic [1:0]          status_in;
   logic [31:0]         removed_in;
   logic                found_in;

   logic [1:0]          status_ff;
   logic [31:0]         removed_ff;
   logic                found_ff;
   logic [4:0]          count_out_ff;
   logic                full_ff;
   logic                empty_ff;

   assign pos_x  = CMPW'(position);
   assign cnt_x  = CMPW'(count_ff);
   assign rm_idx = IXW'(position);

   always_comb begin
      status_in = pls_pkg::STAT_OK;
      do_ins    = 1'b0;
      do_rem    = 1'b0;
      case (command)
         pls_pkg::CMD_INSERT: begin
            if (count_ff == CW'(CAPACITY)) begin
               status_in = pls_pkg::STAT_FULL;
            end else if (pos_x > cnt_x) begin
               status_in = pls_pkg::STAT_BADPOS;
            end else begin
               do_ins = 1'b1;
            end
         end
         pls_pkg::CMD_REMOVE: begin
            if (count_ff == '0) begin
               status_in = pls_pkg::STAT_EMPTY;
            end else if (pos_x >= cnt_x) begin
               status_in = pls_pkg::STAT_BADPOS;
            end else begin
               do_rem = 1'b1;
            end
         end
         default: begin
            status_in = pls_pkg::STAT_OK;
         end
      endcase
   end

   // Each entry sees only its own neighbors and the new value: the whole chain shifts together.
   always_comb begin
      shift_up[0] = value;
      for (int i = 1; i < CAPACITY; i++) begin
         shift_up[i] = entries_ff[i-1];
      end
      for (int i = 0; i < CAPACITY - 1; i++) begin
         shift_down[i] = entries_ff[i+1];
      end
      shift_down[CAPACITY-1] = entries_ff[CAPACITY-1];
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         entries_in[i] = entries_ff[i];
         if (do_ins) begin
            if (CMPW'(i) == pos_x) begin
               entries_in[i] = value;
            end else if (CMPW'(i) > pos_x) begin
               entries_in[i] = shift_up[i];
            end
         end else if (do_rem) begin
            if (CMPW'(i) >= pos_x) begin
               entries_in[i] = shift_down[i];
            end
         end
         hit[i] = (CW'(i) < count_ff) && (entries_ff[i] == value);
      end
   end

   always_comb begin
      removed_in = do_rem ? entries_ff[rm_idx] : 32'd0;
      found_in   = (command == pls_pkg::CMD_SEARCH) && (|hit);
      if (do_ins) begin
         count_in = count_ff + CW'(1);
      end else if (do_rem) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         entries_ff   <= entries_in;
         status_ff    <= status_in;
         removed_ff   <= removed_in;
         found_ff     <= found_in;
         count_out_ff <= 5'(count_in);
         full_ff      <= (count_in == CW'(CAPACITY));
         empty_ff     <= (count_in == '0);
      end
   end

   assign rsp_word = {6'd0, empty_ff, full_ff, count_out_ff, found_ff, removed_ff, status_ff};

endmodule

// ----- sv/positional_sequential_list.sv -----
// Positional sequential list: an ordered list of up to CAPACITY signed 32-bit
// words with insert at a position, remove at a position and search by value.
// Every request word gives exactly one response word carrying the status,
// the removed word, the search hit, the count (low five bits) and the full and
// empty flags. One request is taken per clock while the result register,
// the only buffer, is empty or its response is taken in that cycle: the
// entries sit in a register chain that shifts up or down and compares every
// entry at once, so the response appears in the result register on the
// cycle after acceptance.
// Uses pls_pkg, pls_ctrl and pls_dp.
`timescale 1ns / 1ps

module positional_sequential_list #(
   parameter int CAPACITY = pls_pkg::PLS_CAPACITY
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // command[1:0], position[6:2], value[38:7], zero[39]
   input  logic [pls_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // status[1:0], removed_value[33:2], found[34], count[39:35],
   // is_full[40], is_empty[41], zero[47:42]
   output logic [pls_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   pls_pkg::pls_cmd_type cmd;

   pls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   pls_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .command  (req_tdata[1:0]),
      .position (req_tdata[6:2]),
      .value    (req_tdata[38:7]),
      .rsp_word (rsp_tdata)
   );

`ifndef SYNTH
   // An accepted word always leaves a response waiting on the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("no response after an accepted request");

   // A failed operation never returns a word or a hit.
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != pls_pkg::STAT_OK)
         |-> (rsp_tdata[33:2] == 32'd0 && !rsp_tdata[34]))
      else $error("error response carries data");

   // The list cannot be full and empty at once.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[40] && rsp_tdata[41]))
      else $error("full and empty both set");

   // A search hit and a removed word never appear in the same response.
   a_hit_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[34]) |-> (rsp_tdata[33:2] == 32'd0))
      else $error("search hit with a removed word");
`endif

endmodule
